// ===== sv/hsps_pkg.sv =====
// ----------------------------------------------------------------------------
// Horn signal pattern sequencer package
// Shared types, codes, defaults and the built-in blast pattern table.
// ----------------------------------------------------------------------------
package hsps_pkg;

	localparam int unsigned ELAPSED_W = 20;
	localparam int unsigned CFG_DW    = 20;
	localparam int unsigned CFG_AW    = 3;

	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX  = '1;
	localparam logic [ELAPSED_W-1:0] MORSE_GAP_MS = ELAPSED_W'(200);

	localparam logic [3:0] SOUND_NONE = 4'd0;
	localparam logic [3:0] SOUND_SOS  = 4'd1;
	localparam logic [3:0] SOUND_FOG  = 4'd2;
	localparam logic [3:0] SOUND_STBD = 4'd3;
	localparam logic [3:0] SOUND_PORT = 4'd4;
	localparam logic [3:0] SOUND_ASTN = 4'd5;
	localparam logic [3:0] SOUND_DNGR = 4'd6;
	localparam logic [3:0] SOUND_OTKS = 4'd7;
	localparam logic [3:0] SOUND_OTKP = 4'd8;
	localparam logic [3:0] SOUND_OTKC = 4'd9;
	localparam logic [3:0] SOUND_OTKD = 4'd10;
	localparam logic [3:0] SOUND_LAST = 4'd11;

	localparam logic [3:0] MAX_ELEMS = 4'd9;

	// register indexes
	localparam logic [CFG_AW-1:0] REG_START_DELAY = 3'd0;
	localparam logic [CFG_AW-1:0] REG_SHORT_BLAST = 3'd1;
	localparam logic [CFG_AW-1:0] REG_LONG_BLAST  = 3'd2;
	localparam logic [CFG_AW-1:0] REG_BLAST_GAP   = 3'd3;
	localparam logic [CFG_AW-1:0] REG_MORSE_DOT   = 3'd4;
	localparam logic [CFG_AW-1:0] REG_MORSE_DASH  = 3'd5;
	localparam logic [CFG_AW-1:0] REG_FOG_REPEAT  = 3'd6;
	localparam logic [CFG_AW-1:0] REG_SOS_REPEAT  = 3'd7;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_DELAY  = 3'd1,
		PH_BLAST  = 3'd2,
		PH_GAP    = 3'd3,
		PH_REPEAT = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		EL_SHORT = 2'd0,
		EL_LONG  = 2'd1,
		EL_DOT   = 2'd2,
		EL_DASH  = 2'd3
	} elem_t;

	typedef struct packed {
		logic       command;
		logic [3:0] sound_type;
	} in_t;

	typedef struct packed {
		logic       horn_on;
		logic       playing;
		logic [2:0] phase;
		logic [3:0] blast_number;
		logic [3:0] active_sound;
	} out_t;

	typedef struct packed {
		logic [15:0] start_delay_ms;
		logic [15:0] short_blast_ms;
		logic [15:0] long_blast_ms;
		logic [15:0] blast_gap_ms;
		logic [15:0] morse_dot_ms;
		logic [15:0] morse_dash_ms;
		logic [19:0] fog_repeat_ms;
		logic [19:0] sos_repeat_ms;
	} cfg_t;

	localparam logic [15:0] RST_START_DELAY = 16'd0;
	localparam logic [15:0] RST_SHORT_BLAST = 16'd1000;
	localparam logic [15:0] RST_LONG_BLAST  = 16'd4000;
	localparam logic [15:0] RST_BLAST_GAP   = 16'd1000;
	localparam logic [15:0] RST_MORSE_DOT   = 16'd200;
	localparam logic [15:0] RST_MORSE_DASH  = 16'd600;
	localparam logic [19:0] RST_FOG_REPEAT  = 20'd120000;
	localparam logic [19:0] RST_SOS_REPEAT  = 20'd10000;

	// number of blasts in a pattern; 0 for none and unknown codes
	function automatic logic [3:0] pat_count(input logic [3:0] snd);
		logic [3:0] n;
		unique case (snd)
			SOUND_SOS:  n = MAX_ELEMS;
			SOUND_FOG:  n = 4'd1;
			SOUND_STBD: n = 4'd1;
			SOUND_PORT: n = 4'd2;
			SOUND_ASTN: n = 4'd3;
			SOUND_DNGR: n = 4'd5;
			SOUND_OTKS: n = 4'd3;
			SOUND_OTKP: n = 4'd4;
			SOUND_OTKC: n = 4'd4;
			SOUND_OTKD: n = 4'd5;
			SOUND_LAST: n = 4'd1;
			default:    n = 4'd0;
		endcase
		return n;
	endfunction

	// element kind of blast idx in a pattern (valid only for idx < count)
	function automatic elem_t pat_elem(input logic [3:0] snd, input logic [3:0] idx);
		elem_t e;
		unique case (snd)
			SOUND_SOS:  e = (idx >= 4'd3 && idx <= 4'd5) ? EL_DASH : EL_DOT;
			SOUND_FOG:  e = EL_LONG;
			SOUND_OTKS,
			SOUND_OTKP: e = (idx < 4'd2) ? EL_LONG : EL_SHORT;
			SOUND_OTKC: e = (idx == 4'd0 || idx == 4'd2) ? EL_LONG : EL_SHORT;
			default:    e = EL_SHORT;
		endcase
		return e;
	endfunction

endpackage

// ===== sv/hsps_cfg.sv =====
// ----------------------------------------------------------------------------
// Horn sequencer configuration registers
// Timing registers with reset defaults, written through a plain write port.
// ----------------------------------------------------------------------------
module hsps_cfg import hsps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_wdata,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_delay_ms <= RST_START_DELAY;
			cfg_q.short_blast_ms <= RST_SHORT_BLAST;
			cfg_q.long_blast_ms  <= RST_LONG_BLAST;
			cfg_q.blast_gap_ms   <= RST_BLAST_GAP;
			cfg_q.morse_dot_ms   <= RST_MORSE_DOT;
			cfg_q.morse_dash_ms  <= RST_MORSE_DASH;
			cfg_q.fog_repeat_ms  <= RST_FOG_REPEAT;
			cfg_q.sos_repeat_ms  <= RST_SOS_REPEAT;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_START_DELAY: cfg_q.start_delay_ms <= cfg_wdata[15:0];
				REG_SHORT_BLAST: cfg_q.short_blast_ms <= cfg_wdata[15:0];
				REG_LONG_BLAST:  cfg_q.long_blast_ms  <= cfg_wdata[15:0];
				REG_BLAST_GAP:   cfg_q.blast_gap_ms   <= cfg_wdata[15:0];
				REG_MORSE_DOT:   cfg_q.morse_dot_ms   <= cfg_wdata[15:0];
				REG_MORSE_DASH:  cfg_q.morse_dash_ms  <= cfg_wdata[15:0];
				REG_FOG_REPEAT:  cfg_q.fog_repeat_ms  <= cfg_wdata[19:0];
				REG_SOS_REPEAT:  cfg_q.sos_repeat_ms  <= cfg_wdata[19:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/hsps_seq.sv =====
// ----------------------------------------------------------------------------
// Horn sequencer state and step logic
// Holds the pattern state and computes the state after one tick or request.
// ----------------------------------------------------------------------------
module hsps_seq import hsps_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  in_t  item,
	input  cfg_t cfg,
	output out_t result
);

	phase_t                 phase_q, phase_d;
	logic [3:0]             sound_q, sound_d;
	logic [3:0]             idx_q, idx_d;
	logic [ELAPSED_W-1:0]   el_q, el_d;
	logic                   horn_q, horn_d;

	logic [3:0]             cnt;
	logic [3:0]             idx_inc;
	logic [ELAPSED_W-1:0]   el_inc;
	logic [ELAPSED_W-1:0]   gap;
	logic [ELAPSED_W-1:0]   rep;
	logic [ELAPSED_W-1:0]   dur;
	logic [15:0]            elem_len;
	logic                   known;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			sound_q <= SOUND_NONE;
			idx_q   <= '0;
			el_q    <= '0;
			horn_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			sound_q <= sound_d;
			idx_q   <= idx_d;
			el_q    <= el_d;
			horn_q  <= horn_d;
		end
	end

	always_comb begin
		cnt     = pat_count(sound_q);
		idx_inc = idx_q + 4'd1;
		el_inc  = (el_q == ELAPSED_MAX) ? el_q : el_q + ELAPSED_W'(1);
		gap     = (sound_q == SOUND_SOS) ? MORSE_GAP_MS : ELAPSED_W'(cfg.blast_gap_ms);
		unique case (sound_q)
			SOUND_SOS: rep = cfg.sos_repeat_ms;
			SOUND_FOG: rep = cfg.fog_repeat_ms;
			default:   rep = '0;
		endcase
		unique case (pat_elem(sound_q, idx_q))
			EL_SHORT: elem_len = cfg.short_blast_ms;
			EL_LONG:  elem_len = cfg.long_blast_ms;
			EL_DOT:   elem_len = cfg.morse_dot_ms;
			EL_DASH:  elem_len = cfg.morse_dash_ms;
		endcase
		dur   = (idx_q < cnt) ? ELAPSED_W'(elem_len) : '0;
		known = (item.sound_type != SOUND_NONE) && (item.sound_type <= SOUND_LAST);

		phase_d = phase_q;
		sound_d = sound_q;
		idx_d   = idx_q;
		el_d    = el_q;
		horn_d  = horn_q;

		if (item.command) begin
			// play request: stop, then start unless none or unknown
			horn_d  = 1'b0;
			idx_d   = '0;
			el_d    = '0;
			sound_d = item.sound_type;
			phase_d = known ? PH_DELAY : PH_IDLE;
		end else if (phase_q != PH_IDLE && sound_q != SOUND_NONE && sound_q <= SOUND_LAST) begin
			el_d = el_inc;
			unique case (phase_q)
				PH_DELAY: begin
					if (el_inc >= ELAPSED_W'(cfg.start_delay_ms)) begin
						phase_d = PH_BLAST;
						el_d    = '0;
						horn_d  = 1'b1;
					end
				end
				PH_BLAST: begin
					if (el_inc >= dur) begin
						horn_d = 1'b0;
						idx_d  = idx_inc;
						el_d   = '0;
						if (idx_inc >= cnt) begin
							if (rep != '0) begin
								phase_d = PH_REPEAT;
							end else begin
								phase_d = PH_IDLE;
								idx_d   = '0;
								sound_d = SOUND_NONE;
							end
						end else begin
							phase_d = PH_GAP;
						end
					end
				end
				PH_GAP: begin
					if (el_inc >= gap) begin
						phase_d = PH_BLAST;
						el_d    = '0;
						horn_d  = 1'b1;
					end
				end
				PH_REPEAT: begin
					if (el_inc >= rep) begin
						phase_d = PH_BLAST;
						idx_d   = '0;
						el_d    = '0;
						horn_d  = 1'b1;
					end
				end
				default: begin
					phase_d = PH_IDLE;
					sound_d = SOUND_NONE;
					idx_d   = '0;
					el_d    = '0;
					horn_d  = 1'b0;
				end
			endcase
		end

		result.horn_on      = horn_d;
		result.playing      = (phase_d != PH_IDLE);
		result.phase        = phase_d;
		result.blast_number = idx_d;
		result.active_sound = sound_d;
	end

endmodule

// ===== sv/horn_signal_pattern_sequencer.sv =====
// ----------------------------------------------------------------------------
// Horn signal pattern sequencer
// Steps maritime horn blast patterns on millisecond ticks and play requests.
// ----------------------------------------------------------------------------
// An input transaction passes the input register, then the result register,
// before out_valid rises for its result.
// Throughput: one transaction per cycle unless a stalled result holds the
// output; pattern state updates in the same cycle the input register drains.
// Reset: pattern state goes idle with the horn off; timing registers load
// their defaults. No clearing pass.
module horn_signal_pattern_sequencer import hsps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_t               in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output out_t              out_data,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_wdata
);

	cfg_t  cfg;
	logic  valid_s1;
	in_t   item_s1;
	logic  valid_s2;
	out_t  res_s2;
	out_t  result;
	logic  adv;
	logic  in_acc;

	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;

	hsps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	hsps_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	// horn only sounds inside a blast
	a_horn_in_blast: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.horn_on |-> res_s2.phase == PH_BLAST)
		else $error("horn on outside blast phase");

	a_playing_phase: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> res_s2.playing == (res_s2.phase != PH_IDLE))
		else $error("playing flag disagrees with phase");

	a_playing_sound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.playing |->
			res_s2.active_sound != SOUND_NONE && res_s2.active_sound <= SOUND_LAST)
		else $error("active pattern with unknown sound");

	a_blast_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> res_s2.blast_number <= MAX_ELEMS)
		else $error("blast number past pattern length");

	// a held result must not be overwritten
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && out_stall |=> valid_s2 && $stable(res_s2))
		else $error("stalled result changed");

endmodule

// ===== tb/tb_horn_signal_pattern_sequencer.sv =====
// ----------------------------------------------------------------------------
// Horn signal pattern sequencer testbench
// Drives ticks and play requests through the valid/stall input channel and
// writes timing registers between phases. Each result is checked against an
// in-bench model of the pattern sequencer. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_horn_signal_pattern_sequencer;
	import hsps_pkg::*;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_PLAY = 1'b1;
	localparam int   WATCHDOG_LIMIT = 2000;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	in_t               in_data;
	logic              out_valid;
	logic              out_stall;
	out_t              out_data;
	logic              cfg_we;
	logic [CFG_AW-1:0] cfg_addr;
	logic [CFG_DW-1:0] cfg_wdata;

	// model state and timing copy
	phase_t         pat_phase;
	logic [3:0]     pat_sound;
	logic [3:0]     pat_blast;
	logic [19:0]    pat_elapsed;
	logic           pat_horn;
	cfg_t           timing;

	out_t           pending_states[$];
	out_t           want;
	int             fails = 0;
	int             quiet_cycles = 0;
	bit             idling_on = 1'b1;

	horn_signal_pattern_sequencer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// [21:18] blast count, [2i+1:2i] kind of blast i
	function automatic logic [21:0] pattern_of(input logic [3:0] snd);
		case (snd)
			SOUND_SOS:  return {4'd9, EL_DOT, EL_DOT, EL_DOT, EL_DASH, EL_DASH, EL_DASH,
				EL_DOT, EL_DOT, EL_DOT};
			SOUND_FOG:  return {4'd1, {8{EL_SHORT}}, EL_LONG};
			SOUND_STBD: return {4'd1, {9{EL_SHORT}}};
			SOUND_PORT: return {4'd2, {9{EL_SHORT}}};
			SOUND_ASTN: return {4'd3, {9{EL_SHORT}}};
			SOUND_DNGR: return {4'd5, {9{EL_SHORT}}};
			SOUND_OTKS: return {4'd3, {6{EL_SHORT}}, EL_SHORT, EL_LONG, EL_LONG};
			SOUND_OTKP: return {4'd4, {5{EL_SHORT}}, EL_SHORT, EL_SHORT, EL_LONG, EL_LONG};
			SOUND_OTKC: return {4'd4, {5{EL_SHORT}}, EL_SHORT, EL_LONG, EL_SHORT, EL_LONG};
			SOUND_OTKD: return {4'd5, {9{EL_SHORT}}};
			SOUND_LAST: return {4'd1, {9{EL_SHORT}}};
			default:    return '0;
		endcase
	endfunction

	function automatic void stop_pattern();
		pat_horn    = 1'b0;
		pat_phase   = PH_IDLE;
		pat_blast   = '0;
		pat_elapsed = '0;
		pat_sound   = SOUND_NONE;
	endfunction

	function automatic out_t next_horn_state(input in_t item);
		logic [21:0] pat;
		logic [3:0]  count;
		elem_t       kind;
		logic [19:0] gap, rep, dur;
		out_t        res;
		if (item.command == CMD_PLAY) begin
			stop_pattern();
			pat_sound = item.sound_type;
			if (pat_sound != SOUND_NONE && pat_sound <= SOUND_LAST)
				pat_phase = PH_DELAY;
		end else if (pat_phase != PH_IDLE && pat_sound != SOUND_NONE
				&& pat_sound <= SOUND_LAST) begin
			pat   = pattern_of(pat_sound);
			count = pat[21:18];
			gap   = (pat_sound == SOUND_SOS) ? MORSE_GAP_MS : 20'(timing.blast_gap_ms);
			rep   = (pat_sound == SOUND_SOS) ? timing.sos_repeat_ms :
				(pat_sound == SOUND_FOG) ? timing.fog_repeat_ms : '0;
			if (pat_elapsed != ELAPSED_MAX)
				pat_elapsed++;
			case (pat_phase)
				PH_DELAY: begin
					if (pat_elapsed >= 20'(timing.start_delay_ms)) begin
						pat_phase   = PH_BLAST;
						pat_elapsed = '0;
						pat_horn    = 1'b1;
					end
				end
				PH_BLAST: begin
					dur = '0;
					if (pat_blast < count) begin
						kind = elem_t'(pat[2*pat_blast +: 2]);
						case (kind)
							EL_SHORT: dur = 20'(timing.short_blast_ms);
							EL_LONG:  dur = 20'(timing.long_blast_ms);
							EL_DOT:   dur = 20'(timing.morse_dot_ms);
							default:  dur = 20'(timing.morse_dash_ms);
						endcase
					end
					if (pat_elapsed >= dur) begin
						pat_horn  = 1'b0;
						pat_blast = pat_blast + 4'd1;
						if (pat_blast >= count) begin
							if (rep != '0) begin
								pat_phase   = PH_REPEAT;
								pat_elapsed = '0;
							end else begin
								stop_pattern();
							end
						end else begin
							pat_phase   = PH_GAP;
							pat_elapsed = '0;
						end
					end
				end
				PH_GAP: begin
					if (pat_elapsed >= gap) begin
						pat_horn    = 1'b1;
						pat_phase   = PH_BLAST;
						pat_elapsed = '0;
					end
				end
				PH_REPEAT: begin
					if (pat_elapsed >= rep) begin
						pat_blast   = '0;
						pat_phase   = PH_BLAST;
						pat_elapsed = '0;
						pat_horn    = 1'b1;
					end
				end
				default: stop_pattern();
			endcase
		end
		res.horn_on      = pat_horn;
		res.playing      = (pat_phase != PH_IDLE);
		res.phase        = pat_phase;
		res.blast_number = pat_blast;
		res.active_sound = pat_sound;
		return res;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(input in_t item);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_states.push_back(next_horn_state(item));
		@(negedge clk);
	endtask

	task automatic send_ticks(input int count);
		in_t item;
		for (int i = 0; i < count; i++) begin
			item.command    = CMD_TICK;
			item.sound_type = 4'($urandom_range(0, 15));
			send_item(item);
		end
	endtask

	task automatic request(input logic [3:0] snd);
		in_t item;
		item.command    = CMD_PLAY;
		item.sound_type = snd;
		send_item(item);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_states.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	// writes all eight registers back to back; 16-bit ones get junk upper bits
	task automatic program_timing(input cfg_t t);
		logic [CFG_AW-1:0] addr;
		logic [CFG_DW-1:0] val;
		logic [3:0]        junk;
		for (int i = 0; i < 8; i++) begin
			addr = i[CFG_AW-1:0];
			junk = 4'($urandom_range(0, 15));
			case (addr)
				REG_START_DELAY: val = {junk, t.start_delay_ms};
				REG_SHORT_BLAST: val = {junk, t.short_blast_ms};
				REG_LONG_BLAST:  val = {junk, t.long_blast_ms};
				REG_BLAST_GAP:   val = {junk, t.blast_gap_ms};
				REG_MORSE_DOT:   val = {junk, t.morse_dot_ms};
				REG_MORSE_DASH:  val = {junk, t.morse_dash_ms};
				REG_FOG_REPEAT:  val = t.fog_repeat_ms;
				default:         val = t.sos_repeat_ms;
			endcase
			cfg_we    <= 1'b1;
			cfg_addr  <= addr;
			cfg_wdata <= val;
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		timing = t;
	endtask

	function automatic cfg_t random_timing();
		cfg_t t;
		t.start_delay_ms = 16'($urandom_range(0, 3));
		t.short_blast_ms = 16'($urandom_range(0, 4));
		t.long_blast_ms  = 16'($urandom_range(0, 8));
		t.blast_gap_ms   = 16'($urandom_range(0, 4));
		t.morse_dot_ms   = 16'($urandom_range(0, 3));
		t.morse_dash_ms  = 16'($urandom_range(0, 5));
		t.fog_repeat_ms  = 20'($urandom_range(0, 10));
		t.sos_repeat_ms  = 20'($urandom_range(0, 10));
		if ($urandom_range(0, 7) == 0)
			t.short_blast_ms = 16'($urandom_range(5, 30));
		return t;
	endfunction

	// mostly ticks so patterns get to run; requests interrupt at random
	task automatic send_random(input int count, input int play_pct);
		in_t item;
		int  pick;
		for (int i = 0; i < count; i++) begin
			item.command = ($urandom_range(0, 99) < play_pct) ? CMD_PLAY : CMD_TICK;
			pick = $urandom_range(0, 19);
			if (pick < 14)
				item.sound_type = 4'($urandom_range(SOUND_SOS, SOUND_LAST));
			else if (pick < 17)
				item.sound_type = SOUND_NONE;
			else
				item.sound_type = 4'($urandom_range(SOUND_LAST + 1, 4'hF));
			send_item(item);
		end
	endtask

	// requests under reset timing: stop, unknown codes, every pattern start
	task automatic test_requests();
		send_ticks(1);
		request(SOUND_NONE);
		request(4'hF);
		send_ticks(1);
		request(SOUND_LAST + 4'd1);
		send_ticks(1);
		for (int s = SOUND_SOS; s <= SOUND_LAST; s++) begin
			request(s[3:0]);
			if (s == SOUND_FOG || s == SOUND_LAST)
				send_ticks(2);
		end
		request(SOUND_NONE);
	endtask

	// one-shot ends and a fog repeat restart with short timing
	task automatic test_short_patterns();
		cfg_t t;
		wait_drained();
		t = '{start_delay_ms: 16'd1, short_blast_ms: 16'd1, long_blast_ms: 16'd2,
			blast_gap_ms: 16'd1, morse_dot_ms: 16'd1, morse_dash_ms: 16'd1,
			fog_repeat_ms: 20'd3, sos_repeat_ms: 20'd2};
		program_timing(t);
		request(SOUND_STBD);
		send_ticks(4);
		request(SOUND_OTKC);
		send_ticks(12);
		request(SOUND_FOG);
		send_ticks(10);
	endtask

	// SOS uses the fixed Morse gap, not blast_gap_ms, up to its second blast
	task automatic test_sos_gap();
		cfg_t t;
		int   n;
		wait_drained();
		t = '{start_delay_ms: 16'd0, short_blast_ms: 16'd1, long_blast_ms: 16'd1,
			blast_gap_ms: 16'd1, morse_dot_ms: 16'd1, morse_dash_ms: 16'd2,
			fog_repeat_ms: 20'd1, sos_repeat_ms: 20'd2};
		program_timing(t);
		request(SOUND_SOS);
		n = 0;
		while (!(pat_blast == 4'd1 && pat_phase == PH_BLAST) && n < 1000) begin
			send_ticks(1);
			n++;
		end
		send_ticks(3);
		request(SOUND_NONE);
	endtask

	// largest and zero register values
	task automatic test_extreme_timing();
		cfg_t t;
		wait_drained();
		t = '{start_delay_ms: 16'hFFFF, short_blast_ms: 16'hFFFF, long_blast_ms: 16'hFFFF,
			blast_gap_ms: 16'hFFFF, morse_dot_ms: 16'hFFFF, morse_dash_ms: 16'hFFFF,
			fog_repeat_ms: 20'hFFFFF, sos_repeat_ms: 20'hFFFFF};
		program_timing(t);
		request(SOUND_DNGR);
		send_ticks(3);
		request(SOUND_OTKD);
		send_ticks(2);
		wait_drained();
		program_timing('0);
		// zero repeat makes fog end like a one-shot
		request(SOUND_FOG);
		send_ticks(3);
		request(SOUND_OTKP);
		send_ticks(9);
		request(SOUND_SOS);
		send_ticks(4);
		request(SOUND_NONE);
	endtask

	task automatic test_random_patterns(input int count, input int play_pct);
		wait_drained();
		program_timing(random_timing());
		send_random(count, play_pct);
	endtask

	// sender holds off mid-stream until every result is back
	task automatic test_sender_hold();
		send_random(50, 6);
		wait_drained();
		send_random(50, 6);
	endtask

	task automatic check_field(input string name, input logic [3:0] exp_v,
			input logic [3:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, got_v);
			fails++;
		end
	endtask

	// result checker and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (out_valid && !out_stall) begin
				if (pending_states.size() == 0) begin
					$display("%0t: unexpected result, expected none actual %h", $time, out_data);
					fails++;
				end else begin
					want = pending_states.pop_front();
					check_field("horn_on", 4'(want.horn_on), 4'(out_data.horn_on));
					check_field("playing", 4'(want.playing), 4'(out_data.playing));
					check_field("phase", 4'(want.phase), 4'(out_data.phase));
					check_field("blast_number", want.blast_number, out_data.blast_number);
					check_field("active_sound", want.active_sound, out_data.active_sound);
				end
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: timeout, %0d results outstanding", $time, pending_states.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// result side stalls in bursts
	initial begin : result_stall
		int stall_left;
		stall_left = 0;
		out_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (!idling_on) begin
				stall_left = 0;
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 11);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_addr  = '0;
		cfg_wdata = '0;
		stop_pattern();
		timing = '{start_delay_ms: RST_START_DELAY, short_blast_ms: RST_SHORT_BLAST,
			long_blast_ms: RST_LONG_BLAST, blast_gap_ms: RST_BLAST_GAP,
			morse_dot_ms: RST_MORSE_DOT, morse_dash_ms: RST_MORSE_DASH,
			fog_repeat_ms: RST_FOG_REPEAT, sos_repeat_ms: RST_SOS_REPEAT};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_requests();
		test_short_patterns();
		test_sos_gap();
		test_extreme_timing();
		test_random_patterns(120, 4);
		test_random_patterns(120, 8);
		test_sender_hold();
		wait_drained();
		idling_on = 1'b0;
		test_random_patterns(110, 6);

		wait_drained();
		repeat (10) @(posedge clk);
		if (fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
